### hdl/mpoc_pkg.sv
// Shared types and constants for the multi-phrase occurrence counter.
`timescale 1ns / 1ps

package mpoc_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_PHRASES_DEF    = 4;
    localparam int MAX_PHRASE_LEN_DEF = 8;
    localparam int COUNT_WIDTH_DEF    = 32;

    // Phrases that have configuration registers behind them
    localparam int NUM_CFG_PHRASES = 4;

    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int PHRASE_WIDTH    = 64;
    localparam int LENGTH_WIDTH    = 4;
    localparam int BYTE_WIDTH      = 8;
    localparam int INDEX_WIDTH     = 2;
    localparam int RESULT_WIDTH    = 32;

    // Low bit of a register index picks the field within a phrase
    localparam logic CFG_FIELD_BYTES  = 1'b0;
    localparam logic CFG_FIELD_LENGTH = 1'b1;

    typedef struct packed {
        logic [PHRASE_WIDTH-1:0] phrase_bytes;
        logic [LENGTH_WIDTH-1:0] phrase_length;
    } phrase_cfg_t;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] stream_byte;
        logic                  end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0]  phrase_index;
        logic [RESULT_WIDTH-1:0] match_count;
        logic                    final_result;
    } out_item_t;

endpackage

### hdl/mpoc_cfg_regs.sv
// Phrase configuration register file.
`timescale 1ns / 1ps

module mpoc_cfg_regs #(
    parameter int NUM_PHRASES = mpoc_pkg::NUM_PHRASES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mpoc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [mpoc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output mpoc_pkg::phrase_cfg_t                 phrase_cfg [NUM_PHRASES]
);
    import mpoc_pkg::*;

    phrase_cfg_t phrase_cfg_reg [NUM_PHRASES];
    logic        index_in_range;

    assign cfg_ready      = 1'b1;
    assign index_in_range = (int'(cfg_index) < 2 * NUM_CFG_PHRASES);
    assign phrase_cfg     = phrase_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PHRASES; p++)
            begin
                phrase_cfg_reg[p] <= '0;
            end
        end
        else if (cfg_valid && index_in_range)
        begin
            // Phrases beyond the register set are never written and stay disabled
            for (int p = 0; p < NUM_PHRASES; p++)
            begin
                if (p < NUM_CFG_PHRASES &&
                    int'(cfg_index[CFG_INDEX_WIDTH-1:1]) == p)
                begin
                    if (cfg_index[0] == CFG_FIELD_BYTES)
                    begin
                        phrase_cfg_reg[p].phrase_bytes <= cfg_data[PHRASE_WIDTH-1:0];
                    end
                    else
                    begin
                        phrase_cfg_reg[p].phrase_length <= cfg_data[LENGTH_WIDTH-1:0];
                    end
                end
            end
        end
    end

endmodule

### hdl/mpoc_match_core.sv
// Input register, byte window, parallel phrase compare and match counters.
`timescale 1ns / 1ps

module mpoc_match_core #(
    parameter int NUM_PHRASES    = mpoc_pkg::NUM_PHRASES_DEF,
    parameter int MAX_PHRASE_LEN = mpoc_pkg::MAX_PHRASE_LEN_DEF,
    parameter int COUNT_WIDTH    = mpoc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  mpoc_pkg::in_item_t          in_item,
    input  mpoc_pkg::phrase_cfg_t       phrase_cfg [NUM_PHRASES],
    input  logic                        report_busy,
    output logic                        snap,
    output logic [COUNT_WIDTH-1:0]      snap_counts [NUM_PHRASES]
);
    import mpoc_pkg::*;

    localparam int FILL_W = $clog2(MAX_PHRASE_LEN + 1);

    logic                   s1_valid_reg;
    in_item_t               s1_item_reg;
    logic [BYTE_WIDTH-1:0]  window_reg  [MAX_PHRASE_LEN];
    logic [BYTE_WIDTH-1:0]  window_next [MAX_PHRASE_LEN];
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    logic [COUNT_WIDTH-1:0] count_reg  [NUM_PHRASES];
    logic [COUNT_WIDTH-1:0] count_next [NUM_PHRASES];
    logic [NUM_PHRASES-1:0] hit;
    logic                   fire;

    // Hold a final byte until the report buffer is free
    assign in_stall = s1_valid_reg && s1_item_reg.end_of_stream && report_busy;
    assign fire     = s1_valid_reg && !in_stall;
    assign snap     = fire && s1_item_reg.end_of_stream;

    always_comb
    begin
        window_next[0] = s1_item_reg.stream_byte;
        for (int k = 1; k < MAX_PHRASE_LEN; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
        fill_next = (fill_reg == FILL_W'(MAX_PHRASE_LEN)) ? fill_reg : fill_reg + 1'b1;
    end

    always_comb
    begin
        int  len;
        logic ok;
        for (int p = 0; p < NUM_PHRASES; p++)
        begin
            len = int'(phrase_cfg[p].phrase_length);
            ok  = (len != 0) && (len <= MAX_PHRASE_LEN) && (len <= int'(fill_next));
            // Phrase byte i lines up with window entry len-1-i
            for (int i = 0; i < MAX_PHRASE_LEN; i++)
            begin
                for (int k = 0; k < MAX_PHRASE_LEN; k++)
                begin
                    if ((i + k + 1 == len) &&
                        (window_next[k] != phrase_cfg[p].phrase_bytes[BYTE_WIDTH*i +: BYTE_WIDTH]))
                    begin
                        ok = 1'b0;
                    end
                end
            end
            hit[p] = ok;
        end
    end

    always_comb
    begin
        for (int p = 0; p < NUM_PHRASES; p++)
        begin
            count_next[p] = (hit[p] && !(&count_reg[p])) ? count_reg[p] + 1'b1 : count_reg[p];
        end
    end

    assign snap_counts = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fill_reg     <= '0;
            for (int p = 0; p < NUM_PHRASES; p++)
            begin
                count_reg[p] <= '0;
            end
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (fire)
            begin
                if (s1_item_reg.end_of_stream)
                begin
                    // Drop history and counts once the report is captured
                    fill_reg <= '0;
                    for (int p = 0; p < NUM_PHRASES; p++)
                    begin
                        count_reg[p] <= '0;
                    end
                end
                else
                begin
                    fill_reg  <= fill_next;
                    count_reg <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            s1_item_reg <= in_item;
        end
        if (fire)
        begin
            window_reg <= window_next;
        end
    end

endmodule

### hdl/mpoc_report.sv
// Report buffer and output register that hands out one count per beat.
`timescale 1ns / 1ps

module mpoc_report #(
    parameter int NUM_PHRASES = mpoc_pkg::NUM_PHRASES_DEF,
    parameter int COUNT_WIDTH = mpoc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   snap,
    input  logic [COUNT_WIDTH-1:0] snap_counts [NUM_PHRASES],
    output logic                   report_busy,
    output logic                   out_valid,
    input  logic                   out_stall,
    output mpoc_pkg::out_item_t    out_item
);
    import mpoc_pkg::*;

    localparam int IDX_W = (NUM_PHRASES > 1) ? $clog2(NUM_PHRASES) : 1;

    logic [COUNT_WIDTH-1:0]              rep_count_reg [NUM_PHRASES];
    logic                                busy_reg;
    logic [IDX_W-1:0]                    idx_reg;
    logic                                out_valid_reg;
    out_item_t                           out_item_reg;
    logic                                load;
    logic                                last;
    logic [COUNT_WIDTH+RESULT_WIDTH-1:0] count_ext;
    logic [IDX_W+INDEX_WIDTH-1:0]        idx_ext;

    assign report_busy = busy_reg;
    assign out_valid   = out_valid_reg;
    assign out_item    = out_item_reg;

    assign load      = busy_reg && (!out_valid_reg || !out_stall);
    assign last      = (idx_reg == IDX_W'(NUM_PHRASES - 1));
    assign count_ext = {{RESULT_WIDTH{1'b0}}, rep_count_reg[idx_reg]};
    assign idx_ext   = {{INDEX_WIDTH{1'b0}}, idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (snap)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (load)
            begin
                busy_reg <= !last;
                idx_reg  <= last ? '0 : idx_reg + 1'b1;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap)
        begin
            rep_count_reg <= snap_counts;
        end
        if (load)
        begin
            out_item_reg.phrase_index <= idx_ext[INDEX_WIDTH-1:0];
            out_item_reg.match_count  <= count_ext[RESULT_WIDTH-1:0];
            out_item_reg.final_result <= last;
        end
    end

endmodule

### hdl/multi_phrase_occurrence_counter.sv
// Top level of the multi-phrase occurrence counter.
//
//  channel | signals                                  | direction | beat
//  --------+------------------------------------------+-----------+--------------------------
//  in      | in_valid, in_stall, in_item              | sink      | one stream byte
//  out     | out_valid, out_stall, out_item           | source    | one phrase count
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| sink      | one register write
//
// One byte per cycle unless a final byte is held: a beat lands in the input register, and
// the window and counters take their update from that register when it fires.
// A final byte fills the report buffer, which drains one count per cycle through the output
// register while out_stall is low; a second final byte is held while the buffer drains.
// Reset clears counters, window fill, report state and all configuration registers.
// out_stall holds the output register; bytes flow on until a final byte meets a busy buffer.
`timescale 1ns / 1ps

module multi_phrase_occurrence_counter #(
    parameter int NUM_PHRASES    = mpoc_pkg::NUM_PHRASES_DEF,
    parameter int MAX_PHRASE_LEN = mpoc_pkg::MAX_PHRASE_LEN_DEF,
    parameter int COUNT_WIDTH    = mpoc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  mpoc_pkg::in_item_t                   in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output mpoc_pkg::out_item_t                  out_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mpoc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mpoc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import mpoc_pkg::*;

    phrase_cfg_t            phrase_cfg  [NUM_PHRASES];
    logic                   report_busy;
    logic                   snap;
    logic [COUNT_WIDTH-1:0] snap_counts [NUM_PHRASES];

    mpoc_cfg_regs #(
        .NUM_PHRASES (NUM_PHRASES)
    ) u_cfg_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .phrase_cfg (phrase_cfg)
    );

    mpoc_match_core #(
        .NUM_PHRASES    (NUM_PHRASES),
        .MAX_PHRASE_LEN (MAX_PHRASE_LEN),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_match_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .phrase_cfg  (phrase_cfg),
        .report_busy (report_busy),
        .snap        (snap),
        .snap_counts (snap_counts)
    );

    mpoc_report #(
        .NUM_PHRASES (NUM_PHRASES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_report (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap        (snap),
        .snap_counts (snap_counts),
        .report_busy (report_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

endmodule

### tb/tb_multi_phrase_occurrence_counter.sv
// Testbench for the multi-phrase occurrence counter: directed and random byte streams.
`timescale 1ns / 1ps

module tb_multi_phrase_occurrence_counter;
    import mpoc_pkg::*;

    localparam int NPHR          = NUM_PHRASES_DEF;
    localparam int WIN           = MAX_PHRASE_LEN_DEF;
    localparam int UNUSED_REG    = 2 * NUM_CFG_PHRASES;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_BYTES  = 165;
    localparam int CYCLE_LIMIT   = 100000;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    in_item_t                   in_item   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    out_item_t                  out_item;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    // Predictor state: programmed phrases, byte window and running counts
    logic [PHRASE_WIDTH-1:0] phr_bytes [NPHR];
    logic [LENGTH_WIDTH-1:0] phr_len [NPHR];
    logic [BYTE_WIDTH-1:0]   window [WIN];
    int                      fill;
    logic [RESULT_WIDTH-1:0] counts [NPHR];
    out_item_t               pending_counts [$];

    int  errors       = 0;
    int  cycle_count  = 0;
    int  bytes_sent   = 0;
    int  random_bytes = 0;
    int  reports      = 0;
    int  reg_writes   = 0;
    bit  calm         = 1'b0;

    multi_phrase_occurrence_counter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d counts outstanding", cycle_count,
                     pending_counts.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 24);
    end

    function automatic void clear_stream();
        for (int k = 0; k < WIN; k++)
        begin
            window[k] = '0;
        end
        fill = 0;
        for (int p = 0; p < NPHR; p++)
        begin
            counts[p] = '0;
        end
    endfunction

    function automatic bit phrase_ends(int p);
        int n;
        n = phr_len[p];
        if (n == 0 || n > WIN || n > fill)
        begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            if (window[n-1-i] != phr_bytes[p][8*i +: 8])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Shift one byte into the window, bump matching counts, emit a report on the last byte
    function automatic void count_byte(logic [BYTE_WIDTH-1:0] b, logic last);
        out_item_t r;
        for (int k = WIN - 1; k > 0; k--)
        begin
            window[k] = window[k-1];
        end
        window[0] = b;
        if (fill < WIN)
        begin
            fill++;
        end
        for (int p = 0; p < NPHR; p++)
        begin
            if (phrase_ends(p) && counts[p] != '1)
            begin
                counts[p]++;
            end
        end
        if (last)
        begin
            for (int p = 0; p < NPHR; p++)
            begin
                r.phrase_index = INDEX_WIDTH'(p);
                r.match_count  = counts[p];
                r.final_result = (p == NPHR - 1);
                pending_counts.push_back(r);
            end
            reports++;
            clear_stream();
        end
    endfunction

    always @(posedge clk)
    begin : check_counts
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_counts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected count beat: index %0d count %0d final %0b", $time,
                         out_item.phrase_index, out_item.match_count, out_item.final_result);
            end
            else
            begin
                want = pending_counts.pop_front();
                if (out_item.phrase_index !== want.phrase_index)
                begin
                    errors++;
                    $display("%0t: phrase_index expected %0d got %0d", $time,
                             want.phrase_index, out_item.phrase_index);
                end
                if (out_item.match_count !== want.match_count)
                begin
                    errors++;
                    $display("%0t: match_count (phrase %0d) expected %0d got %0d", $time,
                             want.phrase_index, want.match_count, out_item.match_count);
                end
                if (out_item.final_result !== want.final_result)
                begin
                    errors++;
                    $display("%0t: final_result (phrase %0d) expected %0b got %0b", $time,
                             want.phrase_index, want.final_result, out_item.final_result);
                end
            end
        end
    end

    // Send one stream byte; returns at the edge that accepts the beat
    task automatic push_byte(input logic [BYTE_WIDTH-1:0] b, input logic last);
        if (!calm)
        begin
            while ($urandom_range(99) < 24)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= '{stream_byte: b, end_of_stream: last};
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        count_byte(b, last);
        bytes_sent++;
    endtask

    // Drop valid, drain every outstanding count, then give the pipeline time to settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high so back-to-back writes stay in one burst
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        int p;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        reg_writes++;
        p = idx >> 1;
        if (idx < UNUSED_REG && p < NPHR)
        begin
            if (idx[0] == CFG_FIELD_BYTES)
            begin
                phr_bytes[p] = data;
            end
            else
            begin
                phr_len[p] = data[LENGTH_WIDTH-1:0];
            end
        end
    endtask

    task automatic set_phrase(input logic [2:0] p, input logic [PHRASE_WIDTH-1:0] b,
                              input logic [LENGTH_WIDTH-1:0] n);
        write_reg({p, CFG_FIELD_BYTES}, b);
        write_reg({p, CFG_FIELD_LENGTH}, CFG_DATA_WIDTH'(n));
    endtask

    // Everything is disabled after reset, so extreme bytes give an all-zero report
    task automatic test_reset_state();
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
    endtask

    // Overlapping matches count; lanes beyond a phrase's length are ignored
    task automatic test_overlap_and_lanes();
        wait_idle();
        set_phrase(3'd0, 64'hDEAD_BEEF_0000_4141, 4'd2);
        set_phrase(3'd1, 64'hFFFF_FFFF_FF41_4241, 4'd3);
        set_phrase(3'd2, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        set_phrase(3'd3, 64'hFFFF_FFFF_FFFF_FF00, 4'd1);
        cfg_valid <= 1'b0;
        push_byte(8'h41, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h41, 1'b1);
    endtask

    // Lengths above the window and zero disable a phrase; unused indexes change nothing.
    // An all-zero phrase of full length only matches once the window has filled.
    task automatic test_disabled_lengths();
        wait_idle();
        set_phrase(3'd0, 64'h0, 4'd9);
        set_phrase(3'd1, 64'h0, 4'd15);
        set_phrase(3'd2, 64'h0, 4'd0);
        set_phrase(3'd3, 64'h0, 4'd8);
        write_reg(CFG_INDEX_WIDTH'(UNUSED_REG), 64'h1);
        write_reg(CFG_INDEX_WIDTH'(UNUSED_REG + 7), 64'h0000_0000_0000_0003);
        cfg_valid <= 1'b0;
        repeat (8) push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
    endtask

    // A phrase split across a report boundary must not match
    task automatic test_report_boundary();
        wait_idle();
        set_phrase(3'd0, 64'h4241, 4'd2);
        cfg_valid <= 1'b0;
        push_byte(8'h41, 1'b1);
        push_byte(8'h42, 1'b1);
    endtask

    // Reprogram mid-stream: counts so far are kept, the new phrase applies from the next byte
    task automatic test_midstream_config();
        wait_idle();
        set_phrase(3'd0, 64'h4241, 4'd2);
        set_phrase(3'd1, 64'h4142, 4'd2);
        cfg_valid <= 1'b0;
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h41, 1'b0);
        wait_idle();
        set_phrase(3'd0, 64'h4142, 4'd2);
        set_phrase(3'd1, 64'h0, 4'd0);
        cfg_valid <= 1'b0;
        push_byte(8'h42, 1'b0);
        push_byte(8'h41, 1'b1);
    endtask

    // Random phrases from a small alphabet, streams built mostly from phrase fragments
    task automatic test_random_streams();
        logic [BYTE_WIDTH-1:0]   alpha [4];
        logic [BYTE_WIDTH-1:0]   text [$];
        logic [PHRASE_WIDTH-1:0] pb;
        logic [LENGTH_WIDTH-1:0] pl;
        int                      p;
        int                      n;
        int                      pick;
        int                      target;
        while (random_bytes < RANDOM_BYTES)
        begin
            wait_idle();
            for (int i = 0; i < 4; i++)
            begin
                alpha[i] = BYTE_WIDTH'($urandom_range(255));
            end
            // repeated letters give overlapping matches
            if ($urandom_range(2) == 0)
            begin
                alpha[1] = alpha[0];
            end
            for (int q = 0; q < NPHR; q++)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    pl = '0;
                else if (pick < 18)
                    pl = LENGTH_WIDTH'($urandom_range(9, 15));
                else
                    pl = LENGTH_WIDTH'($urandom_range(1, 8));
                pb = {$urandom, $urandom};
                for (int i = 0; i < pl && i < WIN; i++)
                begin
                    pb[8*i +: 8] = alpha[$urandom_range(3)];
                end
                set_phrase(3'(q), pb, pl);
            end
            if ($urandom_range(3) == 0)
            begin
                write_reg(CFG_INDEX_WIDTH'(UNUSED_REG + $urandom_range(7)), {$urandom, $urandom});
            end
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 3))
            begin
                text.delete();
                target = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
                while (text.size() < target)
                begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                    begin
                        p = $urandom_range(NPHR - 1);
                        n = (phr_len[p] > WIN) ? WIN : phr_len[p];
                        // some fragments are cut short
                        if (pick >= 42)
                        begin
                            n = $urandom_range(n);
                        end
                        for (int i = 0; i < n; i++)
                        begin
                            text.push_back(phr_bytes[p][8*i +: 8]);
                        end
                    end
                    else if (pick < 85)
                    begin
                        text.push_back(alpha[$urandom_range(3)]);
                    end
                    else
                    begin
                        text.push_back(BYTE_WIDTH'($urandom_range(255)));
                    end
                end
                foreach (text[i])
                begin
                    calm = (random_bytes >= 80 && random_bytes < 130);
                    push_byte(text[i], i == text.size() - 1);
                    random_bytes++;
                end
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        for (int p = 0; p < NPHR; p++)
        begin
            phr_bytes[p] = '0;
            phr_len[p]   = '0;
        end
        clear_stream();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_overlap_and_lanes();
        test_disabled_lengths();
        test_report_boundary();
        test_midstream_config();
        test_random_streams();
        wait_idle();

        $display("Covered %0d stream bytes (%0d random) in %0d reports, %0d register writes,",
                 bytes_sent, random_bytes, reports, reg_writes);
        $display("phrase lengths 0 to 15, unused indexes and mid-stream reprogramming");
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
